[src/jsu_pkg.sv]
// shared types, constants and decode functions for the json string unescaper
package jsu_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] BS_BYTE  = 8'h08;
  localparam logic [7:0] FF_BYTE  = 8'h0C;
  localparam logic [7:0] LF_BYTE  = 8'h0A;
  localparam logic [7:0] CR_BYTE  = 8'h0D;
  localparam logic [7:0] TAB_BYTE = 8'h09;

  localparam logic [15:0] CP_1B_MAX = 16'h007F;
  localparam logic [15:0] CP_2B_MAX = 16'h07FF;
  localparam logic [7:0]  LEAD_2B   = 8'hC0;
  localparam logic [7:0]  LEAD_3B   = 8'hE0;
  localparam logic [7:0]  CONT_BYTE = 8'h80;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_TEXT,
    MODE_ESC,
    MODE_HEX
  } mode_t;

  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } raw_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last_of_run;
  } dec_item_t;

  // bytes produced by one input byte, count is 1 to 3
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
    status_t         status;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // {valid, byte}
  function automatic logic [8:0] escape_byte(input logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      CH_QUOTE:  r = {1'b1, CH_QUOTE};
      CH_BSLASH: r = {1'b1, CH_BSLASH};
      CH_SLASH:  r = {1'b1, CH_SLASH};
      CH_B:      r = {1'b1, BS_BYTE};
      CH_F:      r = {1'b1, FF_BYTE};
      CH_N:      r = {1'b1, LF_BYTE};
      CH_R:      r = {1'b1, CR_BYTE};
      CH_T:      r = {1'b1, TAB_BYTE};
      default:   r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

[src/jsu_stream_if.sv]
// valid/ready stream interface carrying one payload per request
interface jsu_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

[src/jsu_front.sv]
// front end: takes source bytes, tracks string mode and builds output runs
module jsu_front (
  input  logic                clk,
  input  logic                rst,
  jsu_stream_if.sink          raw,
  input  jsu_pkg::queue_stat_t qstat,
  output logic                push,
  output jsu_pkg::run_t       run
);
  import jsu_pkg::*;

  mode_t       mode, mode_next;
  logic [11:0] acc, acc_next;
  logic [1:0]  cnt, cnt_next;
  logic        take;
  logic [7:0]  c;
  logic [4:0]  hexd;
  logic [8:0]  escd;
  logic [15:0] cp;

  assign raw.ready = !qstat.full;
  assign take      = raw.valid && raw.ready;
  assign c         = raw.payload.data_byte;
  assign hexd      = hex_digit(c);
  assign escd      = escape_byte(c);
  assign cp        = {acc, hexd[3:0]};

  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    cnt_next  = cnt;
    if (take) begin
      if (raw.payload.first) begin
        acc_next  = '0;
        cnt_next  = '0;
        mode_next = (c == CH_QUOTE) ? MODE_TEXT : MODE_IDLE;
      end else begin
        unique case (mode)
          MODE_IDLE: begin
            mode_next = MODE_IDLE;
          end
          MODE_TEXT: begin
            if (c == CH_BSLASH) begin
              mode_next = MODE_ESC;
            end else if (c == CH_QUOTE || c == CH_NUL) begin
              mode_next = MODE_IDLE;
              acc_next  = '0;
              cnt_next  = '0;
            end
          end
          MODE_ESC: begin
            acc_next = '0;
            cnt_next = '0;
            if (c == CH_U) begin
              mode_next = MODE_HEX;
            end else if (!escd[8]) begin
              mode_next = MODE_IDLE;
            end else begin
              mode_next = MODE_TEXT;
            end
          end
          MODE_HEX: begin
            if (!hexd[4]) begin
              mode_next = MODE_IDLE;
              acc_next  = '0;
              cnt_next  = '0;
            end else if (cnt != 2'd3) begin
              acc_next = cp[11:0];
              cnt_next = cnt + 2'd1;
            end else begin
              mode_next = MODE_TEXT;
              acc_next  = '0;
              cnt_next  = '0;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    push       = 1'b0;
    run        = '0;
    run.count  = 2'd1;
    run.status = ST_DATA;
    if (take) begin
      if (raw.payload.first) begin
        if (c != CH_QUOTE) begin
          push       = 1'b1;
          run.status = ST_ERR;
        end
      end else begin
        unique case (mode)
          MODE_IDLE: begin
            push = 1'b0;
          end
          MODE_TEXT: begin
            if (c == CH_QUOTE) begin
              push       = 1'b1;
              run.status = ST_DONE;
            end else if (c == CH_NUL) begin
              push       = 1'b1;
              run.status = ST_ERR;
            end else if (c != CH_BSLASH) begin
              push         = 1'b1;
              run.bytes[0] = c;
            end
          end
          MODE_ESC: begin
            if (c != CH_U) begin
              push = 1'b1;
              if (escd[8]) begin
                run.bytes[0] = escd[7:0];
              end else begin
                run.status = ST_ERR;
              end
            end
          end
          MODE_HEX: begin
            if (!hexd[4]) begin
              push       = 1'b1;
              run.status = ST_ERR;
            end else if (cnt == 2'd3) begin
              push = 1'b1;
              if (cp <= CP_1B_MAX) begin
                run.bytes[0] = cp[7:0];
              end else if (cp <= CP_2B_MAX) begin
                run.count    = 2'd2;
                run.bytes[0] = LEAD_2B | {3'b000, cp[10:6]};
                run.bytes[1] = CONT_BYTE | {2'b00, cp[5:0]};
              end else begin
                run.count    = 2'd3;
                run.bytes[0] = LEAD_3B | {4'b0000, cp[15:12]};
                run.bytes[1] = CONT_BYTE | {2'b00, cp[11:6]};
                run.bytes[2] = CONT_BYTE | {2'b00, cp[5:0]};
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      acc  <= '0;
      cnt  <= '0;
    end else begin
      mode <= mode_next;
      acc  <= acc_next;
      cnt  <= cnt_next;
    end
  end

`ifndef SYNTHESIS
  a_cnt_only_in_hex: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd0 |-> mode == MODE_HEX)
    else $error("hex digit count set outside hex mode");

  a_run_nonempty: assert property (@(posedge clk) disable iff (rst)
    push |-> run.count != 2'd0)
    else $error("empty run pushed");

  a_end_goes_idle: assert property (@(posedge clk) disable iff (rst)
    push && run.status != ST_DATA |-> run.count == 2'd1 && mode_next == MODE_IDLE)
    else $error("completion or error without a single-entry run and idle");
`endif

endmodule

[src/jsu_queue.sv]
// short queue of output runs between the front and back ends
module jsu_queue #(
  parameter int unsigned DEPTH = jsu_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  jsu_pkg::run_t        wr_run,
  input  logic                 pop,
  output jsu_pkg::run_t        head,
  output jsu_pkg::queue_stat_t stat
);
  import jsu_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  run_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;

  assign head       = slots[rd_ptr];
  assign stat.full  = fill == CW'(DEPTH);
  assign stat.empty = fill == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + CW'(1);
        2'b01:   fill <= fill - CW'(1);
        default: fill <= fill;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !stat.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("queue fill beyond depth");
`endif

endmodule

[src/jsu_back.sv]
// back end: walks each run and presents one result byte per request
module jsu_back (
  input  logic                 clk,
  input  logic                 rst,
  input  jsu_pkg::run_t        head,
  input  jsu_pkg::queue_stat_t qstat,
  output logic                 pop,
  jsu_stream_if.source         decoded
);
  import jsu_pkg::*;

  logic [1:0] sel;
  logic       load;
  logic       last;

  assign load = !qstat.empty && (!decoded.valid || decoded.ready);
  assign last = sel == (head.count - 2'd1);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      decoded.valid <= 1'b0;
      sel           <= '0;
    end else if (load) begin
      decoded.valid <= 1'b1;
      sel           <= last ? 2'd0 : sel + 2'd1;
    end else if (decoded.ready) begin
      decoded.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      decoded.payload.out_byte    <= head.bytes[sel];
      decoded.payload.status      <= head.status;
      decoded.payload.last_of_run <= last;
    end
  end

`ifndef SYNTHESIS
  a_sel_in_run: assert property (@(posedge clk) disable iff (rst)
    !qstat.empty |-> sel < head.count)
    else $error("byte select beyond run length");

  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    !qstat.empty |-> head.count != 2'd0)
    else $error("empty run at queue head");

  a_status_ends_run: assert property (@(posedge clk) disable iff (rst)
    decoded.valid && decoded.payload.status != ST_DATA |-> decoded.payload.last_of_run)
    else $error("completion or error not last of run");
`endif

endmodule

[src/json_string_unescape_utf8_top.sv]
// top level of the json string unescaper with utf-8 output
// Takes one byte of a quoted JSON string per request (first marks the opening
// quote) and returns decoded bytes, a completion result on the closing quote,
// or an error result after which the block idles until the next first byte.
// A backslash-u escape yields 1 to 3 UTF-8 bytes. Input is taken every cycle
// while the run queue is not full; each result is held on the output register
// until taken, so a byte that yields two or three UTF-8 bytes holds the output
// for each of those bytes in turn, and the run queue between front and back ends
// (QUEUE_DEPTH runs) absorbs the burst before the input back-pressures. A result
// reaches the output through a queue entry, then the output register.
module json_string_unescape_utf8_top #(
  parameter int unsigned QUEUE_DEPTH = jsu_pkg::DEF_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  jsu_stream_if.sink   raw,
  jsu_stream_if.source decoded
);
  import jsu_pkg::*;

  run_t        push_run;
  run_t        head;
  queue_stat_t qstat;
  logic        push;
  logic        pop;

  jsu_front u_front (
    .clk   (clk),
    .rst   (rst),
    .raw   (raw),
    .qstat (qstat),
    .push  (push),
    .run   (push_run)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_run (push_run),
    .pop    (pop),
    .head   (head),
    .stat   (qstat)
  );

  jsu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .qstat   (qstat),
    .pop     (pop),
    .decoded (decoded)
  );

endmodule
